// File: design/tsvs_pkg.sv
// ----------------------------------------------------------------------------
// tsvs_pkg
// Shared types and codes for the tube starting-voltage search: register bank
// view, request and result records, operation, command, status, register and
// phase codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tsvs_pkg;

    typedef enum logic [1:0] {OP_START, OP_TICK, OP_MEASURE, OP_HV_ACK} t_op;
    typedef enum logic [1:0] {HV_NONE, HV_ENABLE, HV_DISABLE} t_hv_cmd;
    typedef enum logic [2:0] {
        ST_PENDING, ST_FOUND, ST_NOT_FOUND, ST_HV_ERROR, ST_MEAS_ERROR,
        ST_INVALID, ST_UNSAFE
    } t_status;
    typedef enum logic [2:0] {
        REG_START_V, REG_STEP_INC, REG_STEP_COUNT, REG_THRESHOLD,
        REG_WINDOW, REG_SETTLE, REG_REFERENCE, REG_MAX_DEV
    } t_reg;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_WAIT_ACK = 3'd1;
    localparam logic [2:0] PH_SETTLE   = 3'd2;
    localparam logic [2:0] PH_MEASURE  = 3'd3;
    localparam logic [2:0] PH_DONE     = 3'd4;

    typedef struct packed {
        logic [11:0] init_volt;
        logic [11:0] step_increment;
        logic [7:0]  step_count;
        logic [15:0] event_threshold;
        logic [7:0]  window_seconds;
        logic [15:0] settle_ms;
        logic [11:0] ref_volt;
        logic [7:0]  max_deviation_pct;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  operation;
        logic        hv_ok;
        logic [15:0] meas_events;
        logic        meas_is_new;
        logic        meas_error;
    } t_item;

    typedef struct packed {
        logic [1:0]  hv_command;
        logic [11:0] hv_voltage;
        logic [2:0]  status;
        logic [11:0] onset_volt;
        logic [7:0]  onset_step;
        logic [31:0] onset_events;
        logic        first_step;
        logic        dev_ok;
        logic        done_res;
    } t_result;

endpackage

`default_nettype wire

// File: design/tsvs_in_if.sv
// ----------------------------------------------------------------------------
// tsvs_in_if
// Request channel: operation code and measurement / acknowledge payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsvs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic        hv_ok;
    logic [15:0] meas_events;
    logic        meas_is_new;
    logic        meas_error;

    modport source (
        output valid, operation, hv_ok, meas_events, meas_is_new, meas_error,
        input  ready
    );
    modport sink (
        input  valid, operation, hv_ok, meas_events, meas_is_new, meas_error,
        output ready
    );
endinterface

`default_nettype wire

// File: design/tsvs_out_if.sv
// ----------------------------------------------------------------------------
// tsvs_out_if
// Result channel: HV command and test status / detection record.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsvs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  hv_command;
    logic [11:0] hv_voltage;
    logic [2:0]  status;
    logic [11:0] onset_volt;
    logic [7:0]  onset_step;
    logic [31:0] onset_events;
    logic        first_step;
    logic        dev_ok;
    logic        done_res;

    modport source (
        output valid, hv_command, hv_voltage, status, onset_volt,
               onset_step, onset_events, first_step, dev_ok, done_res,
        input  ready
    );
    modport sink (
        input  valid, hv_command, hv_voltage, status, onset_volt,
               onset_step, onset_events, first_step, dev_ok, done_res,
        output ready
    );
endinterface

`default_nettype wire

// File: design/tsvs_cfg.sv
// ----------------------------------------------------------------------------
// tsvs_cfg
// Configuration register bank, write only.
// ----------------------------------------------------------------------------
`default_nettype none

module tsvs_cfg
    import tsvs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_wdata,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_volt         <= 12'd350;
            r_cfg.step_increment    <= 12'd10;
            r_cfg.step_count        <= 8'd50;
            r_cfg.event_threshold   <= 16'd10;
            r_cfg.window_seconds    <= 8'd10;
            r_cfg.settle_ms         <= 16'd500;
            r_cfg.ref_volt          <= 12'd400;
            r_cfg.max_deviation_pct <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_V:    r_cfg.init_volt         <= i_cfg_wdata[11:0];
                REG_STEP_INC:   r_cfg.step_increment    <= i_cfg_wdata[11:0];
                REG_STEP_COUNT: r_cfg.step_count        <= i_cfg_wdata[7:0];
                REG_THRESHOLD:  r_cfg.event_threshold   <= i_cfg_wdata;
                REG_WINDOW:     r_cfg.window_seconds    <= i_cfg_wdata[7:0];
                REG_SETTLE:     r_cfg.settle_ms         <= i_cfg_wdata;
                REG_REFERENCE:  r_cfg.ref_volt          <= i_cfg_wdata[11:0];
                REG_MAX_DEV:    r_cfg.max_deviation_pct <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: design/tsvs_ctrl.sv
// ----------------------------------------------------------------------------
// tsvs_ctrl
// Search sequencer: updates the test state for each accepted request and
// forms its result record in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tsvs_ctrl
    import tsvs_pkg::*;
#(
    parameter int VOLT_FLOOR     = 0,
    parameter int VOLT_CEIL      = 4095,
    parameter int VOLT_ABS_LIMIT = 4095
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_cfg      i_cfg,
    input  wire logic i_accept,
    input  t_item     i_item,
    output t_result   o_result
);

    localparam logic [11:0] MinV      = 12'(VOLT_FLOOR);
    localparam logic [11:0] MaxV      = 12'(VOLT_CEIL);
    localparam logic [20:0] AbsMaxV   = 21'(VOLT_ABS_LIMIT);
    localparam logic        BadLimits = (VOLT_ABS_LIMIT <= 0) ||
                                        (VOLT_FLOOR > VOLT_CEIL);

    logic [2:0]  r_phase,   n_phase;
    logic [7:0]  r_step,    n_step;
    logic [11:0] r_volt,    n_volt;
    logic [15:0] r_settle,  n_settle;
    logic [7:0]  r_sec,     n_sec;
    logic [31:0] r_sum,     n_sum;
    logic [2:0]  r_status,  n_status;
    logic [11:0] r_fvolt,   n_fvolt;
    logic [7:0]  r_fstep,   n_fstep;
    logic [31:0] r_fevents, n_fevents;
    logic        r_ffirst,  n_ffirst;
    logic        r_fpass,   n_fpass;

    logic [1:0]  cmd;
    logic [11:0] volt;
    logic [19:0] span;
    logic [20:0] last_v;
    logic        cfg_bad;
    logic [7:0]  step_nxt;
    logic [11:0] volt_nxt;
    logic [15:0] settle_inc;
    logic [7:0]  sec_inc;
    logic [32:0] sum_add;
    logic [31:0] sum_new;
    logic [11:0] diff;
    logic [18:0] dev_lhs;
    logic [19:0] dev_rhs;
    logic        pass;

    // datapath terms
    always_comb begin
        span     = 20'(i_cfg.step_count - 8'd1) * 20'(i_cfg.step_increment);
        last_v   = 21'(i_cfg.init_volt) + 21'(span);
        cfg_bad  = (i_cfg.step_count == 8'd0) || (i_cfg.event_threshold == 16'd0) ||
                   (i_cfg.window_seconds == 8'd0) || (i_cfg.step_increment == 12'd0) ||
                   (i_cfg.ref_volt == 12'd0) || BadLimits ||
                   (i_cfg.init_volt < MinV) || (i_cfg.init_volt > MaxV);
        step_nxt = r_step + 8'd1;
        volt_nxt = i_cfg.init_volt +
                   12'(20'(step_nxt) * 20'(i_cfg.step_increment));
        settle_inc = r_settle + 16'd1;
        sec_inc    = r_sec + 8'd1;
        sum_add    = 33'(r_sum) + 33'(i_item.meas_events);
        if (!i_item.meas_is_new) begin
            sum_new = r_sum;
        end else if (sum_add[32]) begin
            sum_new = '1;
        end else begin
            sum_new = sum_add[31:0];
        end
        diff    = (r_volt > i_cfg.ref_volt) ? r_volt - i_cfg.ref_volt
                                            : i_cfg.ref_volt - r_volt;
        dev_lhs = 19'(diff) * 19'd100;
        dev_rhs = 20'(i_cfg.max_deviation_pct) * 20'(i_cfg.ref_volt);
        pass    = 20'(dev_lhs) < dev_rhs;
    end

    // state update
    always_comb begin
        n_phase   = r_phase;
        n_step    = r_step;
        n_volt    = r_volt;
        n_settle  = r_settle;
        n_sec     = r_sec;
        n_sum     = r_sum;
        n_status  = r_status;
        n_fvolt   = r_fvolt;
        n_fstep   = r_fstep;
        n_fevents = r_fevents;
        n_ffirst  = r_ffirst;
        n_fpass   = r_fpass;
        cmd       = HV_NONE;
        volt      = 12'd0;

        case (i_item.operation)
            OP_START: begin
                if (r_phase == PH_IDLE || r_phase == PH_DONE) begin
                    n_fvolt   = 12'd0;
                    n_fstep   = 8'd0;
                    n_fevents = 32'd0;
                    n_ffirst  = 1'b0;
                    n_fpass   = 1'b0;
                    n_step    = 8'd0;
                    n_settle  = 16'd0;
                    n_sec     = 8'd0;
                    n_sum     = 32'd0;
                    if (cfg_bad) begin
                        n_status = ST_INVALID;
                        n_phase  = PH_DONE;
                    end else if (last_v > AbsMaxV) begin
                        n_status = ST_UNSAFE;
                        n_phase  = PH_DONE;
                    end else begin
                        n_status = ST_PENDING;
                        n_volt   = i_cfg.init_volt;
                        cmd      = HV_ENABLE;
                        volt     = i_cfg.init_volt;
                        n_phase  = PH_WAIT_ACK;
                    end
                end
            end
            OP_HV_ACK: begin
                if (r_phase == PH_WAIT_ACK) begin
                    if (!i_item.hv_ok) begin
                        n_status = ST_HV_ERROR;
                        n_phase  = PH_DONE;
                        cmd      = HV_DISABLE;
                    end else begin
                        n_settle = 16'd0;
                        if (i_cfg.settle_ms == 16'd0) begin
                            n_phase = PH_MEASURE;
                            n_sec   = 8'd0;
                            n_sum   = 32'd0;
                        end else begin
                            n_phase = PH_SETTLE;
                        end
                    end
                end
            end
            OP_TICK: begin
                if (r_phase == PH_SETTLE) begin
                    n_settle = settle_inc;
                    if (settle_inc >= i_cfg.settle_ms) begin
                        n_phase = PH_MEASURE;
                        n_sec   = 8'd0;
                        n_sum   = 32'd0;
                    end
                end
            end
            OP_MEASURE: begin
                if (r_phase == PH_MEASURE) begin
                    if (i_item.meas_error) begin
                        n_status = ST_MEAS_ERROR;
                        n_phase  = PH_DONE;
                        cmd      = HV_DISABLE;
                    end else begin
                        n_sum = sum_new;
                        n_sec = sec_inc;
                        if (sec_inc >= i_cfg.window_seconds) begin
                            if (sum_new >= 32'(i_cfg.event_threshold)) begin
                                n_fvolt   = r_volt;
                                n_fstep   = r_step;
                                n_fevents = sum_new;
                                n_ffirst  = (r_step == 8'd0);
                                n_fpass   = pass;
                                n_status  = ST_FOUND;
                                n_phase   = PH_DONE;
                                cmd       = HV_DISABLE;
                            end else if (9'(r_step) + 9'd1 < 9'(i_cfg.step_count)) begin
                                n_step  = step_nxt;
                                n_volt  = volt_nxt;
                                cmd     = HV_ENABLE;
                                volt    = volt_nxt;
                                n_phase = PH_WAIT_ACK;
                            end else begin
                                n_status = ST_NOT_FOUND;
                                n_phase  = PH_DONE;
                                cmd      = HV_DISABLE;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_step    <= 8'd0;
            r_volt    <= 12'd0;
            r_settle  <= 16'd0;
            r_sec     <= 8'd0;
            r_sum     <= 32'd0;
            r_status  <= ST_PENDING;
            r_fvolt   <= 12'd0;
            r_fstep   <= 8'd0;
            r_fevents <= 32'd0;
            r_ffirst  <= 1'b0;
            r_fpass   <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_step    <= n_step;
            r_volt    <= n_volt;
            r_settle  <= n_settle;
            r_sec     <= n_sec;
            r_sum     <= n_sum;
            r_status  <= n_status;
            r_fvolt   <= n_fvolt;
            r_fstep   <= n_fstep;
            r_fevents <= n_fevents;
            r_ffirst  <= n_ffirst;
            r_fpass   <= n_fpass;
        end
    end

    always_comb begin
        o_result.hv_command   = cmd;
        o_result.hv_voltage   = volt;
        o_result.status       = n_status;
        o_result.onset_volt   = n_fvolt;
        o_result.onset_step   = n_fstep;
        o_result.onset_events = n_fevents;
        o_result.first_step   = n_ffirst;
        o_result.dev_ok       = n_fpass;
        o_result.done_res     = (n_phase == PH_DONE);
    end

endmodule

`default_nettype wire

// File: design/tsvs_out_buf.sv
// ----------------------------------------------------------------------------
// tsvs_out_buf
// Result register with a skid stage so the request side can hand over one more
// request while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tsvs_out_buf
    import tsvs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_result    i_data,
    output logic       o_ready,
    tsvs_out_if.source o_res
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free = !r_out_valid || o_res.ready;
    assign o_ready  = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    always_comb begin
        o_res.valid        = r_out_valid;
        o_res.hv_command   = r_out.hv_command;
        o_res.hv_voltage   = r_out.hv_voltage;
        o_res.status       = r_out.status;
        o_res.onset_volt   = r_out.onset_volt;
        o_res.onset_step   = r_out.onset_step;
        o_res.onset_events = r_out.onset_events;
        o_res.first_step   = r_out.first_step;
        o_res.dev_ok       = r_out.dev_ok;
        o_res.done_res     = r_out.done_res;
    end

endmodule

`default_nettype wire

// File: design/tube_starting_voltage_search_core.sv
// ----------------------------------------------------------------------------
// tube_starting_voltage_search_core
// Ramps a detector tube's HV step by step to find its starting voltage.
// Requests on i_req: start, millisecond tick, one-second measurement and
// HV-set acknowledge. Every request gives exactly one result on o_res,
// carrying the HV command to issue (enable at a voltage, or disable) and
// the test status with the detection record.
// Result: each taken request's result is written to the result register,
// or to the skid stage while the receiver stalls. Throughput: one request
// per cycle while i_req.ready is high; the state update and result forming
// are combinational between the state registers and the result register.
// Stall: a result register plus a skid stage; with the receiver stalled
// one more request is taken, then i_req.ready drops until the skid entry moves up.
// Reset: synchronous, active low; registers return to their defaults,
// the test goes idle with status pending and no results are held.
// Configuration writes (i_cfg_we/i_cfg_idx/i_cfg_wdata) apply at the next
// edge and are used by the next request that reads them.
// ----------------------------------------------------------------------------
`default_nettype none

module tube_starting_voltage_search_core
    import tsvs_pkg::*;
#(
    parameter int VOLT_FLOOR     = 0,
    parameter int VOLT_CEIL      = 4095,
    parameter int VOLT_ABS_LIMIT = 4095
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_wdata,
    tsvs_in_if.sink          i_req,
    tsvs_out_if.source       o_res
);

    t_cfg    cfg;
    t_item   item;
    t_result result;
    logic    buf_ready;
    logic    accept;

    assign i_req.ready = buf_ready;
    assign accept      = i_req.valid && buf_ready;

    always_comb begin
        item.operation   = i_req.operation;
        item.hv_ok       = i_req.hv_ok;
        item.meas_events = i_req.meas_events;
        item.meas_is_new = i_req.meas_is_new;
        item.meas_error  = i_req.meas_error;
    end

    tsvs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    tsvs_ctrl #(
        .VOLT_FLOOR     (VOLT_FLOOR),
        .VOLT_CEIL      (VOLT_CEIL),
        .VOLT_ABS_LIMIT (VOLT_ABS_LIMIT)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_item   (item),
        .o_result (result)
    );

    tsvs_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (result),
        .o_ready (buf_ready),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tube_starting_voltage_search_core. A queue-fed
// driver and a clocked monitor surround the block. Each accepted request runs
// through a local model of the HV ramp search. The model covers validation,
// HV set, settling, windowed event sums, detection and the pass test. Every
// result is compared against the queued prediction. A directed part is
// followed by randomized test sequences under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import tsvs_pkg::*;

    typedef struct {
        logic [2:0]  phase;
        logic [7:0]  step;
        logic [11:0] volt;
        logic [15:0] settled;
        logic [7:0]  seconds;
        logic [31:0] sum;
        t_status     status;
        logic [11:0] found_volt;
        logic [7:0]  found_step;
        logic [31:0] found_events;
        logic        found_first;
        logic        found_pass;
    } t_search_state;

    localparam int IDLE_PCT      = 29;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 800;
    localparam int RANDOM_ROUNDS = 8;
    localparam int ABS_MAX_V     = 4095;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_wdata;

    tsvs_in_if  req ();
    tsvs_out_if res ();

    tube_starting_voltage_search_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req),
        .o_res       (res)
    );

    t_cfg          cfg_now;
    t_search_state live_st;
    t_search_state plan_st;
    t_item         request_queue[$];
    t_result       expected_results[$];
    t_item         in_flight;

    bit          sender_idles;
    bit          receiver_idles;
    int          hold_asks;
    int          hold_seen;
    int          hold_left;
    int          errors;
    int          n_sent;
    int          n_results;
    int          n_counted;
    int          ended_by[8];
    int unsigned cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_search_state idle_state();
        t_search_state s;
        s = '{PH_IDLE, '0, '0, '0, '0, '0, ST_PENDING, '0, '0, '0, 1'b0, 1'b0};
        return s;
    endfunction

    // One request through the ramp search: updates the state, returns the result.
    function automatic t_result search_step(ref t_search_state s, input t_cfg c,
                                            input t_item it);
        t_result     r;
        int unsigned last_v;
        int unsigned diff;
        bit          pass;
        r = '0;
        case (it.operation)
            OP_START: begin
                if (s.phase == PH_IDLE || s.phase == PH_DONE) begin
                    s.found_volt = '0;
                    s.found_step = '0;
                    s.found_events = '0;
                    s.found_first = 1'b0;
                    s.found_pass = 1'b0;
                    s.step = '0;
                    s.settled = '0;
                    s.seconds = '0;
                    s.sum = '0;
                    last_v = 32'(c.init_volt)
                           + (32'(c.step_count) - 1) * 32'(c.step_increment);
                    if (c.step_count == 0 || c.event_threshold == 0 ||
                        c.window_seconds == 0 || c.step_increment == 0 ||
                        c.ref_volt == 0) begin
                        s.status = ST_INVALID;
                        s.phase = PH_DONE;
                    end else if (last_v > ABS_MAX_V) begin
                        s.status = ST_UNSAFE;
                        s.phase = PH_DONE;
                    end else begin
                        s.status = ST_PENDING;
                        s.volt = c.init_volt;
                        r.hv_command = HV_ENABLE;
                        r.hv_voltage = s.volt;
                        s.phase = PH_WAIT_ACK;
                    end
                end
            end
            OP_HV_ACK: begin
                if (s.phase == PH_WAIT_ACK) begin
                    if (!it.hv_ok) begin
                        s.status = ST_HV_ERROR;
                        s.phase = PH_DONE;
                        r.hv_command = HV_DISABLE;
                    end else begin
                        s.settled = '0;
                        if (c.settle_ms == 0) begin
                            s.phase = PH_MEASURE;
                            s.seconds = '0;
                            s.sum = '0;
                        end else begin
                            s.phase = PH_SETTLE;
                        end
                    end
                end
            end
            OP_TICK: begin
                if (s.phase == PH_SETTLE) begin
                    s.settled = s.settled + 16'd1;
                    if (s.settled >= c.settle_ms) begin
                        s.phase = PH_MEASURE;
                        s.seconds = '0;
                        s.sum = '0;
                    end
                end
            end
            default: begin
                if (s.phase == PH_MEASURE) begin
                    if (it.meas_error) begin
                        s.status = ST_MEAS_ERROR;
                        s.phase = PH_DONE;
                        r.hv_command = HV_DISABLE;
                    end else begin
                        if (it.meas_is_new) begin
                            if (32'hFFFF_FFFF - s.sum < 32'(it.meas_events))
                                s.sum = 32'hFFFF_FFFF;
                            else
                                s.sum = s.sum + 32'(it.meas_events);
                        end
                        s.seconds = s.seconds + 8'd1;
                        if (s.seconds >= c.window_seconds) begin
                            if (s.sum >= 32'(c.event_threshold)) begin
                                diff = (s.volt > c.ref_volt)
                                     ? 32'(s.volt - c.ref_volt)
                                     : 32'(c.ref_volt - s.volt);
                                pass = (diff * 100) < (32'(c.max_deviation_pct)
                                                     * 32'(c.ref_volt));
                                s.found_volt = s.volt;
                                s.found_step = s.step;
                                s.found_events = s.sum;
                                s.found_first = (s.step == 0);
                                s.found_pass = pass;
                                s.status = ST_FOUND;
                                s.phase = PH_DONE;
                                r.hv_command = HV_DISABLE;
                            end else if (32'(s.step) + 1 < 32'(c.step_count)) begin
                                s.step = s.step + 8'd1;
                                s.volt = 12'(32'(c.init_volt)
                                           + 32'(s.step) * 32'(c.step_increment));
                                r.hv_command = HV_ENABLE;
                                r.hv_voltage = s.volt;
                                s.phase = PH_WAIT_ACK;
                            end else begin
                                s.status = ST_NOT_FOUND;
                                s.phase = PH_DONE;
                                r.hv_command = HV_DISABLE;
                            end
                        end
                    end
                end
            end
        endcase
        r.status = s.status;
        r.onset_volt = s.found_volt;
        r.onset_step = s.found_step;
        r.onset_events = s.found_events;
        r.first_step = s.found_first;
        r.dev_ok = s.found_pass;
        r.done_res = (s.phase == PH_DONE);
        return r;
    endfunction

    function automatic string show_result(t_result r);
        return {$sformatf("cmd=%0d volt=%0d status=%0d start_v=%0d ",
                          r.hv_command, r.hv_voltage, r.status, r.onset_volt),
                $sformatf("step=%0d events=%0d first=%0b pass=%0b done=%0b",
                          r.onset_step, r.onset_events, r.first_step,
                          r.dev_ok, r.done_res)};
    endfunction

    function automatic void flag_error(string what, t_result want, t_result got);
        errors++;
        if (errors <= 10) begin
            $display("%s at result %0d", what, n_results);
            $display("  expected %s", show_result(want));
            $display("  actual   %s", show_result(got));
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req.valid <= 1'b0;
        end else begin
            if (req.valid && req.ready) begin
                expected_results.push_back(search_step(live_st, cfg_now, in_flight));
                n_sent++;
            end
            if (!req.valid || req.ready) begin
                if (request_queue.size() != 0 &&
                    !(sender_idles && $urandom_range(99) < IDLE_PCT)) begin
                    in_flight = request_queue.pop_front();
                    req.valid <= 1'b1;
                    req.operation <= in_flight.operation;
                    req.hv_ok <= in_flight.hv_ok;
                    req.meas_events <= in_flight.meas_events;
                    req.meas_is_new <= in_flight.meas_is_new;
                    req.meas_error <= in_flight.meas_error;
                end else begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // result receiver; a hold request stalls it for a long stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            res.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            res.ready <= 1'b0;
        end else begin
            res.ready <= !(receiver_idles && $urandom_range(99) < IDLE_PCT);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && res.valid && res.ready) begin
            got = {res.hv_command, res.hv_voltage, res.status, res.onset_volt,
                   res.onset_step, res.onset_events, res.first_step,
                   res.dev_ok, res.done_res};
            n_results++;
            if (expected_results.size() == 0) begin
                flag_error("unexpected result", '0, got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want)
                    flag_error("result mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, expected_results.size());
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic set_reg(t_reg idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_START_V:    cfg_now.init_volt = val[11:0];
            REG_STEP_INC:   cfg_now.step_increment = val[11:0];
            REG_STEP_COUNT: cfg_now.step_count = val[7:0];
            REG_THRESHOLD:  cfg_now.event_threshold = val;
            REG_WINDOW:     cfg_now.window_seconds = val[7:0];
            REG_SETTLE:     cfg_now.settle_ms = val;
            REG_REFERENCE:  cfg_now.ref_volt = val[11:0];
            default:        cfg_now.max_deviation_pct = val[7:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Queue one request; the planning copy of the search tracks where the test is.
    task automatic send(t_op op, logic ok, logic [15:0] ev, logic nw, logic er);
        t_item      it;
        t_result    r;
        logic [2:0] was;
        it = {op, ok, ev, nw, er};
        was = plan_st.phase;
        if ((op == OP_START && (was == PH_IDLE || was == PH_DONE)) ||
            (op == OP_HV_ACK && was == PH_WAIT_ACK) ||
            (op == OP_TICK && was == PH_SETTLE) ||
            (op == OP_MEASURE && was == PH_MEASURE))
            n_counted++;
        r = search_step(plan_st, cfg_now, it);
        if (r.done_res && (was != PH_DONE || op == OP_START))
            ended_by[r.status]++;
        request_queue.push_back(it);
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (request_queue.size() != 0 || req.valid || expected_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Event counts scaled so a window lands near the threshold either way.
    function automatic logic [15:0] pick_events();
        int unsigned hi;
        hi = (32'(cfg_now.event_threshold) * 2) / 32'(cfg_now.window_seconds) + 1;
        if (hi > 65535)
            hi = 65535;
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, hi));
        endcase
    endfunction

    task automatic random_request(bit noisy);
        logic [15:0] ev;
        logic        ok;
        logic        nw;
        logic        er;
        ev = 16'($urandom);
        ok = 1'($urandom);
        nw = 1'($urandom);
        er = 1'($urandom);
        if (noisy && $urandom_range(99) < 15) begin
            send(t_op'($urandom_range(0, 3)), ok, ev, nw, er);
        end else begin
            case (plan_st.phase)
                PH_WAIT_ACK: send(OP_HV_ACK, $urandom_range(99) < 97, ev, nw, er);
                PH_SETTLE:   send(OP_TICK, ok, ev, nw, er);
                PH_MEASURE:  send(OP_MEASURE, ok, pick_events(),
                                  $urandom_range(99) < 85, $urandom_range(99) < 1);
                default:     send(OP_START, ok, ev, nw, er);
            endcase
        end
    endtask

    task automatic shuffle_setup();
        int unsigned cnt;
        int unsigned sv;
        int unsigned inc;
        int unsigned rv;
        cnt = $urandom_range(1, 6);
        sv = $urandom_range(0, 3800);
        inc = (4095 - sv) / cnt;
        inc = $urandom_range(1, (inc == 0) ? 1 : inc);
        // now and then a ramp that overruns the HV ceiling
        if ($urandom_range(0, 7) == 0)
            inc = $urandom_range(1, 4095);
        if ($urandom_range(0, 1) != 0)
            rv = sv + $urandom_range(0, 200);
        else
            rv = $urandom_range(1, 4095);
        if (rv > 4095)
            rv = 4095;
        if (rv == 0)
            rv = 1;
        set_reg(REG_START_V, 16'(sv));
        set_reg(REG_STEP_INC, 16'(inc));
        set_reg(REG_STEP_COUNT, 16'(cnt));
        set_reg(REG_THRESHOLD, 16'($urandom_range(1, 3000)));
        set_reg(REG_WINDOW, 16'($urandom_range(1, 4)));
        set_reg(REG_SETTLE, 16'($urandom_range(0, 3)));
        set_reg(REG_REFERENCE, 16'(rv));
        set_reg(REG_MAX_DEV, 16'($urandom_range(0, 255)));
    endtask

    initial begin
        t_reg must_be_set[5];
        int   target;
        must_be_set = '{REG_STEP_INC, REG_STEP_COUNT, REG_THRESHOLD, REG_WINDOW,
                        REG_REFERENCE};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        req.valid = 1'b0;
        req.operation = '0;
        req.hv_ok = 1'b0;
        req.meas_events = '0;
        req.meas_is_new = 1'b0;
        req.meas_error = 1'b0;
        res.ready = 1'b0;
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        // register defaults after reset
        cfg_now = {12'd350, 12'd10, 8'd50, 16'd10, 8'd10, 16'd500, 12'd400, 8'd10};
        live_st = idle_state();
        plan_st = idle_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // default settings: stray items, a start, HV refused
        send(OP_TICK, 1'b0, 16'h0000, 1'b0, 1'b0);
        send(OP_START, 1'b0, 16'h0000, 1'b0, 1'b0);
        send(OP_START, 1'b1, 16'hFFFF, 1'b1, 1'b1);
        send(OP_HV_ACK, 1'b0, 16'h0000, 1'b0, 1'b0);
        send(OP_MEASURE, 1'b0, 16'h1234, 1'b1, 1'b0);
        drain();

        // each zero setting rejects a start on its own
        foreach (must_be_set[k]) begin
            set_reg(must_be_set[k], 16'd0);
            send(OP_START, 1'b0, 16'h0000, 1'b0, 1'b0);
            drain();
            set_reg(must_be_set[k], 16'd1);
        end

        // ramp past the HV ceiling
        set_reg(REG_START_V, 16'hFFFF);
        set_reg(REG_STEP_INC, 16'hFFFF);
        set_reg(REG_STEP_COUNT, 16'd2);
        set_reg(REG_SETTLE, 16'hFFFF);
        set_reg(REG_WINDOW, 16'd255);
        send(OP_START, 1'b0, 16'h0000, 1'b0, 1'b0);
        drain();

        // single step at full scale, no settle, detection on the first step
        set_reg(REG_STEP_COUNT, 16'd1);
        set_reg(REG_SETTLE, 16'd0);
        set_reg(REG_WINDOW, 16'd1);
        set_reg(REG_THRESHOLD, 16'hFFFF);
        set_reg(REG_REFERENCE, 16'd4095);
        set_reg(REG_MAX_DEV, 16'd0);
        send(OP_START, 1'b0, 16'h0000, 1'b0, 1'b0);
        send(OP_HV_ACK, 1'b1, 16'h0000, 1'b0, 1'b0);
        send(OP_MEASURE, 1'b0, 16'hFFFF, 1'b1, 1'b0);
        drain();

        // settling, start while busy, stale counts, next step, read failure
        set_reg(REG_START_V, 16'd0);
        set_reg(REG_STEP_INC, 16'd1);
        set_reg(REG_STEP_COUNT, 16'd255);
        set_reg(REG_THRESHOLD, 16'd1);
        set_reg(REG_WINDOW, 16'd2);
        set_reg(REG_SETTLE, 16'd2);
        set_reg(REG_REFERENCE, 16'd1);
        set_reg(REG_MAX_DEV, 16'd255);
        send(OP_START, 1'b0, 16'h0000, 1'b0, 1'b0);
        send(OP_HV_ACK, 1'b1, 16'h0000, 1'b0, 1'b0);
        send(OP_TICK, 1'b0, 16'h0000, 1'b0, 1'b0);
        send(OP_START, 1'b0, 16'h0000, 1'b0, 1'b0);
        send(OP_TICK, 1'b0, 16'h0000, 1'b0, 1'b0);
        send(OP_MEASURE, 1'b0, 16'hFFFF, 1'b0, 1'b0);
        send(OP_MEASURE, 1'b0, 16'h0000, 1'b1, 1'b0);
        send(OP_HV_ACK, 1'b1, 16'h0000, 1'b0, 1'b0);
        send(OP_TICK, 1'b0, 16'h0000, 1'b0, 1'b0);
        send(OP_TICK, 1'b0, 16'h0000, 1'b0, 1'b0);
        send(OP_MEASURE, 1'b0, 16'h0000, 1'b1, 1'b1);

        // random test sequences: one round without idles, one with a long stall
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            drain();
            shuffle_setup();
            sender_idles = (round != 2);
            receiver_idles = (round != 2);
            if (round == 5)
                hold_asks++;
            target = n_counted + RANDOM_ITEMS / RANDOM_ROUNDS;
            while (n_counted < target)
                random_request(1'b1);
            // finish the running test so the next setup lands on an idle block
            while (!(plan_st.phase inside {PH_IDLE, PH_DONE}))
                random_request(1'b0);
        end
        drain();
        repeat (20) @(negedge i_clk);
        errors += expected_results.size();

        $display("%0d requests, %0d results checked, %0d errors",
                 n_sent, n_results, errors);
        $display("%s%s",
                 $sformatf("tests ended: found %0d, not found %0d, HV error %0d, ",
                           ended_by[ST_FOUND], ended_by[ST_NOT_FOUND],
                           ended_by[ST_HV_ERROR]),
                 $sformatf("read error %0d, invalid %0d, unsafe %0d",
                           ended_by[ST_MEAS_ERROR], ended_by[ST_INVALID],
                           ended_by[ST_UNSAFE]));
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
